@@ hw/rtl/sync_length_packet_deframer_unit_macros.svh @@
// Assertion macros shared by the deframer checker.
// No dependencies; included by files that carry assertions.
`ifndef SYNC_LENGTH_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define SYNC_LENGTH_PACKET_DEFRAMER_UNIT_MACROS_SVH

// Implication checked at every rising clock edge unless the disable term is true.
`define SLPD_ASSERT_IMPLY(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked at the following clock edge.
`define SLPD_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/slpd_pkg.sv @@
// Shared types and constants of the sync/length packet deframer.
// No dependencies; imported by every module of the block.
package slpd_pkg;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [BYTE_W-1:0] MIN_TOTAL_LEN  = 8'd3;
    localparam logic [BYTE_W-1:0] MAX_LEN_RESET  = 8'd255;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH  = 2'd2;

    // Index of the length byte within a three-word header burst.
    localparam logic [1:0] HDR_LAST_IDX = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_LEN   = 2'd2,
        PH_BODY  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] max_length;
    } t_cfg;

    // One classified byte handed from the front to the back.
    typedef struct packed {
        logic              hdr;      // emit sync pair, then data
        logic [BYTE_W-1:0] sync_a;
        logic [BYTE_W-1:0] sync_b;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_cmd;

endpackage

@@ hw/rtl/slpd_front.sv @@
// Front end of the deframer: sync hunt, length check and body count.
// Depends on slpd_pkg; feeds commands into slpd_cmdq.
module slpd_front import slpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_q_full,
    input  t_cfg              i_cfg,
    output logic              o_q_push,
    output t_cmd              o_q_cmd
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_left, n_left;
    logic              accept;
    logic [BYTE_W-1:0] body_left;
    logic [BYTE_W-1:0] len_left;

    assign accept    = i_push && !i_q_full;
    assign body_left = (r_left != '0) ? r_left - 8'd1 : r_left;
    assign len_left  = i_rx_byte - MIN_TOTAL_LEN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_left  <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_left           = r_left;
        o_q_push         = 1'b0;
        o_q_cmd.hdr      = 1'b0;
        o_q_cmd.sync_a   = i_cfg.sync_first;
        o_q_cmd.sync_b   = i_cfg.sync_second;
        o_q_cmd.data     = i_rx_byte;
        o_q_cmd.last     = 1'b0;
        if (accept) begin
            case (r_phase)
                PH_HUNT1: begin
                    if (i_rx_byte == i_cfg.sync_first) n_phase = PH_HUNT2;
                end
                PH_HUNT2: begin
                    if (i_rx_byte == i_cfg.sync_second)     n_phase = PH_LEN;
                    else if (i_rx_byte == i_cfg.sync_first) n_phase = PH_HUNT2;
                    else                                     n_phase = PH_HUNT1;
                end
                PH_LEN: begin
                    if (i_rx_byte > i_cfg.max_length || i_rx_byte < MIN_TOTAL_LEN) begin
                        n_phase = PH_HUNT1;
                        n_left  = '0;
                    end else begin
                        n_left       = len_left;
                        o_q_push     = 1'b1;
                        o_q_cmd.hdr  = 1'b1;
                        o_q_cmd.last = (len_left == '0);
                        n_phase      = (len_left == '0) ? PH_HUNT1 : PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_left       = body_left;
                    o_q_push     = 1'b1;
                    o_q_cmd.last = (body_left == '0);
                    if (body_left == '0) n_phase = PH_HUNT1;
                end
                default: begin
                    n_phase = PH_HUNT1;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/slpd_cmdq.sv @@
// Short command queue between the front and the back of the deframer.
// Depends on slpd_pkg for the command type.
module slpd_cmdq import slpd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

@@ hw/rtl/slpd_back.sv @@
// Back end of the deframer: expands commands into output words and holds
// the output register. Depends on slpd_pkg.
module slpd_back import slpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_cmd              i_q_head,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_is_last
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [1:0]        r_idx, n_idx;
    logic              load, take, done;
    logic [BYTE_W-1:0] sel_byte;
    logic              sel_last;

    assign load = !r_valid || i_pop;
    assign take = load && !i_q_empty;
    assign done = !i_q_head.hdr || (r_idx == HDR_LAST_IDX);
    assign o_q_pop = take && done;

    always_comb begin
        sel_byte = i_q_head.data;
        sel_last = i_q_head.last;
        if (i_q_head.hdr) begin
            case (r_idx)
                2'd0: begin
                    sel_byte = i_q_head.sync_a;
                    sel_last = 1'b0;
                end
                2'd1: begin
                    sel_byte = i_q_head.sync_b;
                    sel_last = 1'b0;
                end
                default: begin
                    sel_byte = i_q_head.data;
                    sel_last = i_q_head.last;
                end
            endcase
        end
        n_idx = r_idx;
        if (take) n_idx = done ? 2'd0 : r_idx + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) r_valid <= !i_q_empty;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= sel_byte;
            r_last <= sel_last;
        end
    end

    assign o_empty    = !r_valid;
    assign o_out_byte = r_byte;
    assign o_is_last  = r_last;

endmodule

@@ hw/rtl/sync_length_packet_deframer_unit.sv @@
// Top level of the sync/length packet deframer: configuration registers,
// front end, command queue and back end. Depends on slpd_pkg and the slpd_* modules.
//
// The deframer takes received bytes one word at a time on a push/full port and
// returns validated packets on an empty/pop port. It hunts for the two-byte
// sync pair given by sync_first and sync_second, where a repeated first sync
// byte keeps the hunt going and a match with the second sync byte wins when
// both sync bytes are equal. The byte after the pair is the total packet
// length, counting both sync bytes and itself; a length above max_length or
// below three drops the packet and the hunt resumes. A good packet comes out
// as the sync pair, the length byte and the body bytes, with is_last set on
// the final word. The input side accepts one word per cycle whenever the
// command queue has room: the front end classifies each byte in the cycle
// it is accepted. A good length byte becomes one queued command that the back
// end expands into three output words, every other queued command gives one
// word, so the output side sustains one word per cycle while it is popped and
// the queue (QUEUE_DEPTH entries) absorbs the header bursts. An accepted word
// is written into the command queue, then loaded into the output register.
// The output register is refilled in the same cycle its word is popped, so
// pops on consecutive cycles see one word per cycle while the queue has words;
// while a word waits for pop, the queue holds the rest. Registers are at byte
// addresses 0, 4 and 8 and should be written only while no packet is in flight.
module sync_length_packet_deframer_unit import slpd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Received bytes.
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // Packet bytes.
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_is_last,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    logic q_push, q_pop, q_full, q_empty;
    t_cmd q_cmd, q_head;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= '0;
            r_cfg.sync_second <= '0;
            r_cfg.max_length  <= MAX_LEN_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SYNC_FIRST:  r_cfg.sync_first  <= pwdata[BYTE_W-1:0];
                REG_SYNC_SECOND: r_cfg.sync_second <= pwdata[BYTE_W-1:0];
                REG_MAX_LENGTH:  r_cfg.max_length  <= pwdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Reads of the unused address return zero.
    always_comb begin
        case (reg_idx)
            REG_SYNC_FIRST:  prdata = DATA_W'(r_cfg.sync_first);
            REG_SYNC_SECOND: prdata = DATA_W'(r_cfg.sync_second);
            REG_MAX_LENGTH:  prdata = DATA_W'(r_cfg.max_length);
            default:         prdata = '0;
        endcase
    end

    // The input side is ready whenever the command queue has room.
    assign full = q_full;

    slpd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .i_cfg     (r_cfg),
        .o_q_push  (q_push),
        .o_q_cmd   (q_cmd)
    );

    slpd_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    slpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_head   (q_head),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_is_last  (o_is_last)
    );

endmodule

@@ hw/rtl/slpd_checker.sv @@
// Port-level checker for the deframer, bound to the top level.
// Depends on slpd_pkg and sync_length_packet_deframer_unit_macros.svh.
`include "sync_length_packet_deframer_unit_macros.svh"

module slpd_checker import slpd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic [BYTE_W-1:0] o_out_byte,
    input logic              o_is_last,
    input logic              pready
);

    // Reset leaves both sides idle: no result waiting and room for input.
    `SLPD_ASSERT_NEXT(a_reset_idle, i_clk, 1'b0, !i_rst_n, empty && !full)

    // A waiting word that is not taken stays on the ports unchanged.
    `SLPD_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, !empty && !pop,
                      !empty && $stable(o_out_byte) && $stable(o_is_last))

    // The configuration port never stalls.
    `SLPD_ASSERT_IMPLY(a_pready, i_clk, 1'b0, 1'b1, pready)

    // A full queue cannot drain within the cycle unless a word leaves.
    `SLPD_ASSERT_NEXT(a_full_hold, i_clk, !i_rst_n, full && (empty || !pop) && !empty,
                      full)

endmodule

bind sync_length_packet_deframer_unit slpd_checker u_slpd_checker (.*);

@@ verif/sync_length_packet_deframer_unit_tb.sv @@
// Self-checking testbench for the sync/length packet deframer top level.
// It depends on slpd_pkg and the deframer RTL, and needs no other files.
`timescale 1ns / 1ps

module sync_length_packet_deframer_unit_tb;
    import slpd_pkg::*;

    // Register addresses on the configuration port: index times four.
    localparam logic [ADDR_W-1:0] ADDR_SYNC_FIRST  = {REG_SYNC_FIRST, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SYNC_SECOND = {REG_SYNC_SECOND, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_MAX_LENGTH  = {REG_MAX_LENGTH, 2'b00};
    // The fourth slot holds no register, so a write there must change nothing.
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED    = 4'hC;

    // Cycles to let pass once nothing is expected: the path runs through the
    // queue and output register; a dropped byte may still be in flight at the end.
    localparam int SETTLE_CYCLES  = 10;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int DIR_ROWS       = 34;
    localparam int LONG_LEN       = 32;

    typedef enum logic {
        ACT_WRITE,
        ACT_BYTE
    } t_act;

    // One word of a validated packet, as the result side presents it.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_pkt_word;

    // One row of the directed plan. A typed row carries its expected words:
    // none, the body byte itself, or the sync pair followed by the length byte.
    typedef struct packed {
        t_act              act;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] val;
        logic              typed;
        logic [1:0]        n_words;
        logic [BYTE_W-1:0] e_sync_a;
        logic [BYTE_W-1:0] e_sync_b;
        logic              e_last;
    } t_plan_row;

    localparam t_plan_row UNTYPED = '{ACT_BYTE, '0, '0, 1'b0, 2'd0, '0, '0, 1'b0};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] i_rx_byte = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_is_last;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Predictor state: the hunt phase, the body count and its own register copy.
    t_phase            pred_phase = PH_HUNT1;
    logic [BYTE_W-1:0] pred_left = '0;
    t_cfg              pred_cfg = '{sync_first: 8'd0, sync_second: 8'd0,
                                    max_length: MAX_LEN_RESET};
    t_pkt_word         step_words [3];

    // Words the block still owes, oldest first.
    t_pkt_word         pending_words [$];

    int                mismatches = 0;
    int                cycle_count = 0;
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    logic              rx_hold = 1'b0;
    int                bytes_sent = 0;

    t_plan_row         dir_plan [DIR_ROWS];

    sync_length_packet_deframer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_rx_byte  (i_rx_byte),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_is_last  (o_is_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 i_clk = ~i_clk;

    // A hard stop in case the block hangs on either side.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s, got %0h, expected %0h, cycle %0d", what, got, want,
                 cycle_count);
        mismatches++;
    endtask

    // Advances the predictor by one received byte and leaves the words it
    // causes in step_words. Returns how many there are.
    function automatic int deframe_step(input logic [BYTE_W-1:0] b);
        int n;
        n = 0;
        case (pred_phase)
            PH_HUNT1: begin
                if (b == pred_cfg.sync_first) pred_phase = PH_HUNT2;
            end
            PH_HUNT2: begin
                // The second sync byte wins over a repeated first one, which
                // matters when the two sync bytes are equal.
                if (b == pred_cfg.sync_second) pred_phase = PH_LEN;
                else if (b != pred_cfg.sync_first) pred_phase = PH_HUNT1;
            end
            PH_LEN: begin
                if (b > pred_cfg.max_length || b < MIN_TOTAL_LEN) begin
                    pred_phase = PH_HUNT1;
                    pred_left  = '0;
                end else begin
                    pred_left     = b - MIN_TOTAL_LEN;
                    step_words[0] = '{pred_cfg.sync_first, 1'b0};
                    step_words[1] = '{pred_cfg.sync_second, 1'b0};
                    step_words[2] = '{b, pred_left == 0};
                    n             = 3;
                    pred_phase    = (pred_left == 0) ? PH_HUNT1 : PH_BODY;
                end
            end
            default: begin
                if (pred_left > 0) pred_left = pred_left - 1'b1;
                step_words[0] = '{b, pred_left == 0};
                n             = 1;
                if (pred_left == 0) pred_phase = PH_HUNT1;
            end
        endcase
        return n;
    endfunction

    // Offers one byte, with random idle cycles ahead of it, and waits until it
    // is taken. push stays high afterwards so the next byte can follow at once.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input t_plan_row spec);
        int n;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
        n = deframe_step(b);
        if (spec.typed) begin
            // The predictor still runs so that its state follows the stream.
            if (spec.n_words == 2'd3) begin
                pending_words.push_back('{spec.e_sync_a, 1'b0});
                pending_words.push_back('{spec.e_sync_b, 1'b0});
            end
            if (spec.n_words != 2'd0) pending_words.push_back('{b, spec.e_last});
        end else begin
            for (int k = 0; k < n; k++) pending_words.push_back(step_words[k]);
        end
    endtask

    // Stops offering and waits until every expected word has come, plus a
    // margin for bytes that cause no word.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes a register, with random junk in the unused upper data bits, and
    // reads it back where a register exists. The port returns to idle at the end.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value);
        logic [31:0]       junk;
        logic [BYTE_W-1:0] want;
        logic              mapped;
        junk   = $urandom;
        mapped = 1'b1;
        case (addr[3:2])
            REG_SYNC_FIRST:  pred_cfg.sync_first  = value;
            REG_SYNC_SECOND: pred_cfg.sync_second = value;
            REG_MAX_LENGTH:  pred_cfg.max_length  = value;
            default:         mapped = 1'b0;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {junk[DATA_W-1:BYTE_W], value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (mapped) begin
            want    = value;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            if (prdata[BYTE_W-1:0] !== want) begin
                report_mismatch("register read-back", prdata, 32'(want));
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: checks every word taken against the oldest expectation,
    // then decides whether to pop at the next edge. A long hold-off forces
    // the internal queue to fill so that full has to push back on the sender.
    always @(posedge i_clk) begin : result_side
        t_pkt_word want;
        if (i_rst_n && pop && !empty) begin
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing expected", 32'(o_out_byte), '0);
            end else begin
                want = pending_words.pop_front();
                if (o_out_byte !== want.data) begin
                    report_mismatch("out_byte", 32'(o_out_byte), 32'(want.data));
                end
                if (o_is_last !== want.last) begin
                    report_mismatch("is_last", 32'(o_is_last), 32'(want.last));
                end
            end
        end
        if (rx_hold) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Register settings of the random phases, extremes first.
    task automatic pick_phase_cfg(input int p, output logic [BYTE_W-1:0] sf,
                                  output logic [BYTE_W-1:0] ss, output logic [BYTE_W-1:0] ml);
        sf = BYTE_W'($urandom_range(255));
        ss = BYTE_W'($urandom_range(255));
        ml = BYTE_W'($urandom_range(255, 3));
        case (p)
            0: begin
                sf = 8'h00;
                ss = 8'hFF;
                ml = 8'd255;
            end
            1: begin
                sf = 8'hFF;
                ss = 8'h00;
                ml = MIN_TOTAL_LEN;
            end
            2: begin
                ss = sf;
                ml = BYTE_W'($urandom_range(20, 3));
            end
            3: ml = BYTE_W'($urandom_range(2));
            4: ml = 8'd255;
            default: ;
        endcase
    endtask

    // Mostly well-formed packets with random content; the rest is line noise,
    // repeated first sync bytes, broken sync pairs and bad lengths.
    task automatic send_traffic(input int budget, input logic long_first);
        int   ml;
        int   len;
        int   body_max;
        int   kind;
        logic first;
        first = long_first;
        ml    = int'(pred_cfg.max_length);
        while (bytes_sent < budget) begin
            kind = $urandom_range(99);
            if (kind < 12) begin
                send_byte(BYTE_W'($urandom_range(255)), UNTYPED);
            end else begin
                send_byte(pred_cfg.sync_first, UNTYPED);
                if (kind < 20) send_byte(pred_cfg.sync_first, UNTYPED);
                if (kind >= 20 && kind < 28) begin
                    send_byte(BYTE_W'($urandom_range(255)), UNTYPED);
                end else begin
                    send_byte(pred_cfg.sync_second, UNTYPED);
                    body_max = (ml < 12) ? ml : 12;
                    if (first && ml >= LONG_LEN) begin
                        len = LONG_LEN;
                    end else if (ml >= 3 && $urandom_range(99) < 80) begin
                        len = $urandom_range(body_max, 3);
                    end else if (ml < 255 && $urandom_range(1) == 1) begin
                        len = $urandom_range(255, ml + 1);
                    end else begin
                        len = $urandom_range(2);
                    end
                    first = 1'b0;
                    send_byte(BYTE_W'(len), UNTYPED);
                    if (len >= 3 && len <= ml) begin
                        for (int k = 3; k < len; k++) begin
                            send_byte(BYTE_W'($urandom_range(255)), UNTYPED);
                        end
                    end
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [BYTE_W-1:0] sf;
        logic [BYTE_W-1:0] ss;
        logic [BYTE_W-1:0] ml;
        int                budget;

        // Directed plan. Header rows list the sync pair; the length byte and
        // body bytes come back as they went in.
        dir_plan = '{
            '{ACT_WRITE, ADDR_SYNC_FIRST,  8'hA5, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_WRITE, ADDR_SYNC_SECOND, 8'h5A, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_WRITE, ADDR_UNMAPPED,    8'h77, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
            // Noise, then a repeated first sync byte that keeps the hunt going,
            // then the shortest packet: the length byte is the last word.
            '{ACT_BYTE,  4'h0, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'hA5, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'hA5, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h5A, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h03, 1'b1, 2'd3, 8'hA5, 8'h5A, 1'b1},
            // A length below three is dropped.
            '{ACT_BYTE,  4'h0, 8'hA5, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h5A, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h02, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            // Two body bytes at the extremes of the byte range.
            '{ACT_BYTE,  4'h0, 8'hA5, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h5A, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h05, 1'b1, 2'd3, 8'hA5, 8'h5A, 1'b0},
            '{ACT_BYTE,  4'h0, 8'hFF, 1'b1, 2'd1, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h00, 1'b1, 2'd1, 8'h00, 8'h00, 1'b1},
            // A length above the maximum is dropped; one at it passes.
            '{ACT_WRITE, ADDR_MAX_LENGTH,  8'h04, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'hA5, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h5A, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h05, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'hA5, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h5A, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h04, 1'b1, 2'd3, 8'hA5, 8'h5A, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h80, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
            // Equal sync bytes: the second one completes the pair.
            '{ACT_WRITE, ADDR_SYNC_FIRST,  8'hFF, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_WRITE, ADDR_SYNC_SECOND, 8'hFF, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_WRITE, ADDR_MAX_LENGTH,  8'hFF, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'hFF, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'hFF, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h03, 1'b1, 2'd3, 8'hFF, 8'hFF, 1'b1},
            // A maximum below three drops every packet.
            '{ACT_WRITE, ADDR_MAX_LENGTH,  8'h02, 1'b0, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'hFF, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'hFF, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0},
            '{ACT_BYTE,  4'h0, 8'h03, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 21;
        rx_idle_pct = 71;
        foreach (dir_plan[i]) begin
            if (dir_plan[i].act == ACT_WRITE) begin
                wait_drained();
                write_reg(dir_plan[i].addr, dir_plan[i].val);
            end else begin
                send_byte(dir_plan[i].val, dir_plan[i]);
            end
        end

        // Random phases: two with the sender idling less than the receiver,
        // two the other way round, two with no idling at all. Every phase
        // starts from an idle block, so registers are only written then.
        bytes_sent = 0;
        budget     = 0;
        for (int p = 0; p < 6; p++) begin
            tx_idle_pct = (p < 2) ? 21 : (p < 4) ? 71 : 0;
            rx_idle_pct = (p < 2) ? 71 : (p < 4) ? 21 : 0;
            wait_drained();
            pick_phase_cfg(p, sf, ss, ml);
            write_reg(ADDR_SYNC_FIRST, sf);
            write_reg(ADDR_SYNC_SECOND, ss);
            write_reg(ADDR_MAX_LENGTH, ml);
            if (p == 4) begin
                // The receiver stalls while the sender keeps offering bytes.
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            // The phase that drops everything gets only a short stretch.
            budget = budget + ((p == 3) ? 12 : 28);
            send_traffic(budget, p == 4);
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
